>>> design/murmur3_32_stream_hash_unit_macros.svh
// Assertion macros for the MurmurHash3 stream hash unit.
// Used by the top level only; assumes ports named clock and reset in scope.
`ifndef MURMUR3_32_STREAM_HASH_UNIT_MACROS_SVH
`define MURMUR3_32_STREAM_HASH_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define M3H_ASSERT_HOLD(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define M3H_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds while reset is asserted.
`define M3H_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/m3h_pkg.sv
// Shared types, constants and helper functions for the MurmurHash3 stream hash unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package m3h_pkg;

   // MurmurHash3 x86_32 mixing constants.
   localparam logic [31:0] MUR_C1  = 32'hcc9e2d51;
   localparam logic [31:0] MUR_C2  = 32'h1b873593;
   localparam logic [31:0] MUR_ADD = 32'he6546b64;
   localparam logic [31:0] MUR_F1  = 32'h85ebca6b;
   localparam logic [31:0] MUR_F2  = 32'hc2b2ae35;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // How a word is folded into the running hash.
   typedef enum logic [1:0] {
      KIND_FULL,
      KIND_TAIL,
      KIND_NONE
   } m3h_kind_type;

   // One classified word, with its first multiply already done.
   typedef struct packed {
      logic [31:0]  k1;
      m3h_kind_type kind;
      logic [2:0]   add_len;
      logic         last;
   } m3h_item_type;

   function automatic logic [31:0] rotl15(input logic [31:0] x);
      return {x[16:0], x[31:17]};
   endfunction

   function automatic logic [31:0] rotl13(input logic [31:0] x);
      return {x[18:0], x[31:19]};
   endfunction

endpackage

`default_nettype wire

>>> design/m3h_front.sv
// Front end: accepts message words, classifies them and runs the first key multiply.
// Depends on m3h_pkg for the item type and mixing constants.
`timescale 1ns / 1ps
`default_nettype none

module m3h_front import m3h_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [31:0]  req_data_word,
   input  wire logic [2:0]   req_byte_count,
   input  wire logic         req_last,
   output logic              out_valid,
   input  wire logic         out_ready,
   output m3h_item_type      out_item
);

   logic         valid_ff;
   logic         valid_in;
   m3h_item_type item_ff;
   m3h_item_type item_in;
   logic [31:0]  mask;
   logic [31:0]  masked_word;
   logic         take;

   // The stage takes a new transaction when empty or when its item leaves.
   assign req_ready = !valid_ff || out_ready;
   assign take      = req_valid && req_ready;

   // A non-last word, or any word with four or more bytes, is a full block.
   always_comb begin
      item_in = item_ff;
      mask    = 32'h0;
      if (!req_last || (req_byte_count inside {[3'd4:3'd7]})) begin
         item_in.kind    = KIND_FULL;
         item_in.add_len = 3'd4;
         mask            = 32'hffff_ffff;
      end else if (req_byte_count == 3'd0) begin
         item_in.kind    = KIND_NONE;
         item_in.add_len = 3'd0;
      end else begin
         item_in.kind    = KIND_TAIL;
         item_in.add_len = req_byte_count;
         case (req_byte_count)
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            default: mask = 32'h00ff_ffff;
         endcase
      end
      masked_word  = req_data_word & mask;
      item_in.k1   = masked_word * MUR_C1;
      item_in.last = req_last;
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   // Control state is reset; the payload loads only on a transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

>>> design/m3h_queue.sv
// Short FIFO that decouples the front end from the hash sequencer.
// Depends on m3h_pkg for the item type and queue depth.
`timescale 1ns / 1ps
`default_nettype none

module m3h_queue import m3h_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   output logic              push_ready,
   input  wire m3h_item_type push_item,
   output logic              pop_valid,
   input  wire logic         pop,
   output m3h_item_type      pop_item
);

   m3h_item_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_CNT_W-1:0]   count_in;
   logic                     do_push;
   logic                     do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_item   = mem_ff[rd_ptr_ff];

   // Pointer wrap and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> design/m3h_back.sv
// Back end: sequencer that mixes words into the running hash and runs the finalizer.
// Depends on m3h_pkg for the item type, constants and rotate helpers.
`timescale 1ns / 1ps
`default_nettype none

module m3h_back import m3h_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [31:0]  seed,
   input  wire logic         q_valid,
   input  wire m3h_item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [31:0]       rsp_hash_value
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX,
      ST_UPDATE,
      ST_FIN1,
      ST_FIN2,
      ST_FIN3
   } state_type;

   state_type    state_ff;
   state_type    state_in;
   m3h_item_type cur_ff;
   m3h_item_type cur_in;
   logic [31:0]  k_ff;
   logic [31:0]  k_in;
   logic [31:0]  hash_ff;
   logic [31:0]  hash_in;
   logic [31:0]  len_ff;
   logic [31:0]  len_in;
   logic         in_msg_ff;
   logic         in_msg_in;
   logic [31:0]  acc_ff;
   logic [31:0]  acc_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic [31:0]  rsp_hash_ff;
   logic [31:0]  rsp_hash_in;

   logic [31:0]  h_start;
   logic [31:0]  len_start;
   logic [31:0]  h_xor;
   logic [31:0]  h_rot;
   logic [31:0]  h_next;
   logic [31:0]  len_next;
   logic [31:0]  fin_a;
   logic [31:0]  fin_b;
   logic         can_emit;

   // The seed is taken in on the first word of each message.
   assign h_start   = in_msg_ff ? hash_ff : seed;
   assign len_start = in_msg_ff ? len_ff : 32'h0;
   assign h_xor     = h_start ^ k_ff;
   assign h_rot     = rotl13(h_xor);
   assign len_next  = len_start + {29'd0, cur_ff.add_len};

   // Running hash update: block mix, tail fold, or nothing for an empty tail.
   always_comb begin
      case (cur_ff.kind)
         KIND_FULL: h_next = (h_rot << 2) + h_rot + MUR_ADD;
         KIND_TAIL: h_next = h_xor;
         default:   h_next = h_start;
      endcase
   end

   // Finalizer shift-xor steps ahead of each multiply; fin_a also gives the final shift-xor of the result.
   assign fin_a    = acc_ff ^ (acc_ff >> 16);
   assign fin_b    = acc_ff ^ (acc_ff >> 13);
   assign can_emit = !rsp_valid_ff || rsp_ready;

   // A new item leaves the queue from idle, or during a non-last update.
   assign q_pop = q_valid &&
                  ((state_ff == ST_IDLE) || ((state_ff == ST_UPDATE) && !cur_ff.last));

   // Next-state and datapath logic.
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      hash_in      = hash_ff;
      len_in       = len_ff;
      in_msg_in    = in_msg_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      if (q_pop) begin
         cur_in = q_item;
      end
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            k_in     = rotl15(cur_ff.k1) * MUR_C2;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!cur_ff.last) begin
               hash_in   = h_next;
               len_in    = len_next;
               in_msg_in = 1'b1;
               state_in  = q_pop ? ST_MIX : ST_IDLE;
            end else begin
               acc_in    = h_next ^ len_next;
               in_msg_in = 1'b0;
               state_in  = ST_FIN1;
            end
         end
         ST_FIN1: begin
            acc_in   = fin_a * MUR_F1;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            acc_in   = fin_b * MUR_F2;
            state_in = ST_FIN3;
         end
         ST_FIN3: begin
            if (can_emit) begin
               rsp_hash_in  = fin_a;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_msg_ff    <= in_msg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      k_ff        <= k_in;
      hash_ff     <= hash_in;
      len_ff      <= len_in;
      acc_ff      <= acc_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

`default_nettype wire

>>> design/murmur3_32_stream_hash_unit.sv
// Inside a message the back sequencer handles one word at a time: a key multiply step
// and then a hash update step, during which it may take the next word from the queue.
// A last word is followed by the finalizer steps before the result is emitted.
// A 2-entry queue lets the front keep accepting while the back is busy.
// Reset is synchronous and active high; it clears all control state and the seed to 0.
`timescale 1ns / 1ps
`default_nettype none
`include "murmur3_32_stream_hash_unit_macros.svh"

module murmur3_32_stream_hash_unit import m3h_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [31:0]  csr_seed,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [31:0]  req_data_word,
   input  wire logic [2:0]   req_byte_count,
   input  wire logic         req_last,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [31:0]       rsp_hash_value
);

   logic [31:0]  seed_ff;
   logic [31:0]  seed_in;
   logic         fr_valid;
   logic         fr_ready;
   m3h_item_type fr_item;
   logic         q_valid;
   logic         q_pop;
   m3h_item_type q_item;

   // Seed register; a write transaction is always taken.
   assign csr_ready = 1'b1;
   assign seed_in   = (csr_valid && csr_ready) ? csr_seed : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'h0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // Front end: classify and pre-multiply each word.
   m3h_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .out_valid      (fr_valid),
      .out_ready      (fr_ready),
      .out_item       (fr_item)
   );

   // Decoupling queue.
   m3h_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_item  (fr_item),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_item   (q_item)
   );

   // Back end: hash sequencer and finalizer.
   m3h_back u_back (
      .clock          (clock),
      .reset          (reset),
      .seed           (seed_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

   // The back end never pops an empty queue.
   `M3H_ASSERT_HOLD(a_pop_not_empty, q_pop, q_valid, "pop from empty queue")

   // A front item blocked by a full queue holds until it is pushed.
   `M3H_ASSERT_NEXT(a_front_holds, fr_valid && !fr_ready, fr_valid && $stable(fr_item), "front item dropped or changed while stalled")

   // Reset leaves no result pending.
   `M3H_ASSERT_ALWAYS_NEXT(a_reset_clears_rsp, reset, !rsp_valid, "result valid after reset")

endmodule

`default_nettype wire

>>> dv/murmur3_32_stream_hash_unit_tb.sv
// Self-checking testbench for the MurmurHash3 x86 32-bit stream hash unit.
// It drives the word and result channels with random idling, writes seeds on the seed channel, and predicts every hash
// with its own scoreboard. It needs only the murmur3_32_stream_hash_unit RTL, its package and macro header.
`timescale 1ns / 1ps

module murmur3_32_stream_hash_unit_tb;

   // MurmurHash3 x86_32 constants, kept locally so a wrong package constant is caught.
   localparam logic [31:0] KEY_MUL_1   = 32'hcc9e2d51;
   localparam logic [31:0] KEY_MUL_2   = 32'h1b873593;
   localparam logic [31:0] ROUND_ADD   = 32'he6546b64;
   localparam logic [31:0] AVAL_MUL_1  = 32'h85ebca6b;
   localparam logic [31:0] AVAL_MUL_2  = 32'hc2b2ae35;

   localparam int DRAIN_CYCLES   = 40;
   localparam int LONG_STALL     = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_WORDS    = 230;
   localparam int NUM_PHASES     = 6;
   localparam int IDLE_PERCENT   = 26;

   // Scoreboard: predicts the hash of each message and holds the hashes still to come.
   class hash_scoreboard;
      bit [31:0]   seed_value;
      bit [31:0]   chain_hash;
      bit [31:0]   length_count;
      bit          mid_message;
      bit [31:0]   expected_hashes[$];
      int unsigned mismatches;

      function new();
         seed_value   = '0;
         chain_hash   = '0;
         length_count = '0;
         mid_message  = 1'b0;
         mismatches   = 0;
      endfunction

      function bit [31:0] rotate_left(bit [31:0] x, int unsigned r);
         return (x << r) | (x >> (32 - r));
      endfunction

      function bit [31:0] mix_key(bit [31:0] k);
         bit [31:0] m;
         m = k * KEY_MUL_1;
         m = rotate_left(m, 15);
         m = m * KEY_MUL_2;
         return m;
      endfunction

      function bit [31:0] avalanche(bit [31:0] h);
         bit [31:0] f;
         f = h ^ (h >> 16);
         f = f * AVAL_MUL_1;
         f = f ^ (f >> 13);
         f = f * AVAL_MUL_2;
         f = f ^ (f >> 16);
         return f;
      endfunction

      function void set_seed(bit [31:0] value);
         seed_value = value;
      endfunction

      // Fold one accepted word into the running hash; a last word yields a hash.
      function void note_word(bit [31:0] word, bit [2:0] count, bit is_last);
         bit [31:0] h;
         bit [31:0] mask;
         if (!mid_message) begin
            chain_hash   = seed_value;
            length_count = '0;
         end
         h = chain_hash;
         // Non-last words always count as four bytes; counts above four saturate.
         if (!is_last || count >= 3'd4) begin
            h = h ^ mix_key(word);
            h = rotate_left(h, 13);
            h = h * 32'd5 + ROUND_ADD;
            length_count = length_count + 32'd4;
         end else if (count != 3'd0) begin
            mask = (32'h1 << (8 * count)) - 32'h1;
            h = h ^ mix_key(word & mask);
            length_count = length_count + 32'(count);
         end
         if (!is_last) begin
            chain_hash  = h;
            mid_message = 1'b1;
         end else begin
            h = h ^ length_count;
            expected_hashes.push_back(avalanche(h));
            chain_hash   = seed_value;
            length_count = '0;
            mid_message  = 1'b0;
         end
      endfunction

      function void check_hash(logic [31:0] actual);
         bit [31:0] want;
         if (expected_hashes.size() == 0) begin
            $error("hash_value: expected none, actual 0x%08h", actual);
            mismatches++;
         end else begin
            want = expected_hashes.pop_front();
            if (actual !== want) begin
               $error("hash_value: expected 0x%08h, actual 0x%08h", want, actual);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_hashes.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_seed;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_data_word;
   logic [2:0]  req_byte_count;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_hash_value;

   hash_scoreboard sb = new();
   bit             idle_enabled = 1'b1;
   bit             stall_request = 1'b0;
   int             stall_left = 0;
   int             quiet_cycles = 0;

   murmur3_32_stream_hash_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_seed       (csr_seed),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

   // 4 ns clock.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Monitor: every transaction is seen at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_hash(rsp_hash_value);
         end
         if (req_valid && req_ready) begin
            sb.note_word(req_data_word, req_byte_count, req_last);
         end
         if (csr_valid && csr_ready) begin
            sb.set_seed(csr_seed);
         end
      end
   end

   // Watchdog: ends the run when no transaction happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Result receiver: random back-pressure, plus one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left = stall_left - 1;
         end else if (stall_request) begin
            stall_request = 1'b0;
            stall_left = LONG_STALL - 1;
            rsp_ready <= 1'b0;
         end else if (idle_enabled) begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one word and hold it until its transaction completes. Starts and ends at a
   // falling edge; valid stays high on return so back-to-back words need no gap.
   task automatic send_word(input logic [31:0] word, input logic [2:0] count,
                            input logic is_last);
      while (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_word  <= word;
      req_byte_count <= count;
      req_last       <= is_last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stop offering, wait for every predicted hash, then let the block settle.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_seed  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One message: mostly well-formed, with the odd long message and malformed counts.
   task automatic send_random_message(output int words_sent);
      int          full_words;
      int          r;
      logic [2:0]  count;
      full_words = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(5, 0);
      for (int i = 0; i < full_words; i++) begin
         count = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4;
         send_word($urandom, count, 1'b0);
      end
      r = $urandom_range(15);
      if (r < 13) begin
         count = 3'(r % 5);
      end else begin
         count = 3'($urandom_range(7, 5));
      end
      send_word($urandom, count, 1'b1);
      words_sent = full_words + 1;
   endtask

   initial begin
      int          words;
      int          sent;
      logic [31:0] phase_seed;

      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_seed       = '0;
      req_valid      = 1'b0;
      req_data_word  = '0;
      req_byte_count = '0;
      req_last       = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty message, every last-word count, masked bytes, saturated counts.
      send_word(32'h0000_0000, 3'd0, 1'b1);
      send_word(32'hffff_ffff, 3'd1, 1'b1);
      send_word(32'hffff_ffff, 3'd2, 1'b1);
      send_word(32'hffff_ffff, 3'd3, 1'b1);
      send_word(32'hffff_ffff, 3'd4, 1'b1);
      send_word(32'hffff_ffff, 3'd5, 1'b1);
      send_word(32'h0000_0000, 3'd6, 1'b1);
      send_word(32'h8000_0001, 3'd7, 1'b1);
      // Short and oversized counts on words that are not last count as full words.
      send_word(32'h1234_5678, 3'd1, 1'b0);
      send_word(32'ha5a5_a5a5, 3'd3, 1'b1);
      send_word(32'hffff_ffff, 3'd0, 1'b0);
      send_word(32'h0000_0000, 3'd7, 1'b0);
      send_word(32'hdead_beef, 3'd2, 1'b1);
      // Seed written in the middle of a message applies only from the next message.
      send_word(32'h0000_0000, 3'd4, 1'b0);
      send_word(32'hffff_ffff, 3'd4, 1'b0);
      quiesce();
      write_seed(32'hffff_ffff);
      send_word(32'h5a5a_5a5a, 3'd3, 1'b1);
      send_word(32'h0000_0000, 3'd0, 1'b1);
      send_word(32'hffff_ffff, 3'd4, 1'b1);
      send_word(32'h7fff_ffff, 3'd1, 1'b1);

      // Random phases, each under its own seed.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       phase_seed = 32'h0000_0000;
            1:       phase_seed = 32'hffff_ffff;
            3:       phase_seed = 32'h0000_0001;
            4:       phase_seed = 32'h8000_0000;
            default: phase_seed = $urandom;
         endcase
         quiesce();
         write_seed(phase_seed);
         // One phase runs with no idling on either side.
         idle_enabled = (phase != 2);
         // One phase starts with a long receiver hold-off so the block backs up.
         if (phase == 4) begin
            stall_request = 1'b1;
         end
         words = 0;
         while (words < PHASE_WORDS) begin
            send_random_message(sent);
            words = words + sent;
         end
      end

      quiesce();
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
